@@ design/onewire_temperature_reader_macros.svh @@
// ----------------------------------------------------------------------------
// One-wire temperature reader assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_TEMPERATURE_READER_MACROS_SVH
`define ONEWIRE_TEMPERATURE_READER_MACROS_SVH

`ifndef SYNTHESIS
`define OWTR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("owtr assertion failed");
`define OWTR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("owtr assertion failed");
`else
`define OWTR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OWTR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/owtr_pkg.sv @@
// ----------------------------------------------------------------------------
// One-wire temperature reader package
// Payload types, register indexes, sequencer phases and bus commands.
// ----------------------------------------------------------------------------
package owtr_pkg;

  localparam int unsigned RegWidth = 10;

  typedef struct packed {
    logic line_level;
    logic start_convert;
    logic start_read;
  } in_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               no_device;
    logic               is_read_result;
    logic signed [15:0] temperature_raw;
  } out_t;

  typedef enum logic [2:0] {
    RegResetLow     = 3'd0,
    RegPresenceWait = 3'd1,
    RegPresenceEnd  = 3'd2,
    RegShortLow     = 3'd3,
    RegSlot         = 3'd4,
    RegSampleDelay  = 3'd5,
    RegReadTail     = 3'd6,
    RegWriteTail    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [RegWidth-1:0] reset_low_us;
    logic [RegWidth-1:0] presence_wait_us;
    logic [RegWidth-1:0] presence_end_us;
    logic [RegWidth-1:0] short_low_us;
    logic [RegWidth-1:0] slot_us;
    logic [RegWidth-1:0] sample_delay_us;
    logic [RegWidth-1:0] read_tail_us;
    logic [RegWidth-1:0] write_tail_us;
  } cfg_t;

  localparam logic [RegWidth-1:0] ResetLowDflt     = 10'd500;
  localparam logic [RegWidth-1:0] PresenceWaitDflt = 10'd100;
  localparam logic [RegWidth-1:0] PresenceEndDflt  = 10'd300;
  localparam logic [RegWidth-1:0] ShortLowDflt     = 10'd2;
  localparam logic [RegWidth-1:0] SlotDflt         = 10'd60;
  localparam logic [RegWidth-1:0] SampleDelayDflt  = 10'd10;
  localparam logic [RegWidth-1:0] ReadTailDflt     = 10'd50;
  localparam logic [RegWidth-1:0] WriteTailDflt    = 10'd2;

  localparam logic [7:0] CmdSkipRom = 8'hCC;
  localparam logic [7:0] CmdConvert = 8'h44;
  localparam logic [7:0] CmdReadPad = 8'hBE;

  localparam logic [1:0] ByteCmd0  = 2'd0;
  localparam logic [1:0] ByteCmd1  = 2'd1;
  localparam logic [1:0] ByteData0 = 2'd2;
  localparam logic [1:0] ByteData1 = 2'd3;

  typedef enum logic [8:0] {
    PhIdle     = 9'b000000001,
    PhRstLow   = 9'b000000010,
    PhPresWait = 9'b000000100,
    PhPresEnd  = 9'b000001000,
    PhWrLow    = 9'b000010000,
    PhWrRel    = 9'b000100000,
    PhRdLow    = 9'b001000000,
    PhRdWait   = 9'b010000000,
    PhRdTail   = 9'b100000000
  } phase_e;

endpackage

@@ design/owtr_cfg.sv @@
// ----------------------------------------------------------------------------
// One-wire temperature reader timing registers
// Eight 10-bit timing registers written through a plain write port.
// ----------------------------------------------------------------------------
module owtr_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [owtr_pkg::RegWidth-1:0]       cfg_wdata_i,
  output owtr_pkg::cfg_t                      cfg_o
);

  owtr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (owtr_pkg::reg_idx_e'(cfg_idx_i))
        owtr_pkg::RegResetLow:     cfg_d.reset_low_us     = cfg_wdata_i;
        owtr_pkg::RegPresenceWait: cfg_d.presence_wait_us = cfg_wdata_i;
        owtr_pkg::RegPresenceEnd:  cfg_d.presence_end_us  = cfg_wdata_i;
        owtr_pkg::RegShortLow:     cfg_d.short_low_us     = cfg_wdata_i;
        owtr_pkg::RegSlot:         cfg_d.slot_us          = cfg_wdata_i;
        owtr_pkg::RegSampleDelay:  cfg_d.sample_delay_us  = cfg_wdata_i;
        owtr_pkg::RegReadTail:     cfg_d.read_tail_us     = cfg_wdata_i;
        owtr_pkg::RegWriteTail:    cfg_d.write_tail_us    = cfg_wdata_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_us     <= owtr_pkg::ResetLowDflt;
      cfg_q.presence_wait_us <= owtr_pkg::PresenceWaitDflt;
      cfg_q.presence_end_us  <= owtr_pkg::PresenceEndDflt;
      cfg_q.short_low_us     <= owtr_pkg::ShortLowDflt;
      cfg_q.slot_us          <= owtr_pkg::SlotDflt;
      cfg_q.sample_delay_us  <= owtr_pkg::SampleDelayDflt;
      cfg_q.read_tail_us     <= owtr_pkg::ReadTailDflt;
      cfg_q.write_tail_us    <= owtr_pkg::WriteTailDflt;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/owtr_seq.sv @@
// ----------------------------------------------------------------------------
// One-wire temperature reader sequencer
// Bus phase state machine, advanced by one step per microsecond tick.
// ----------------------------------------------------------------------------
module owtr_seq #(
  parameter int unsigned COUNTER_WIDTH = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  owtr_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  owtr_pkg::in_t  item_i,
  output owtr_pkg::out_t res_o
);

  localparam logic [16:0] CntMax = 17'((1 << COUNTER_WIDTH) - 1);

  // Clamp a duration to [1, counter max].
  function automatic logic [COUNTER_WIDTH-1:0] dur(input logic [owtr_pkg::RegWidth-1:0] v);
    logic [16:0] ext;
    ext = 17'(v);
    if (ext == 17'd0) begin
      ext = 17'd1;
    end else if (ext > CntMax) begin
      ext = CntMax;
    end
    return ext[COUNTER_WIDTH-1:0];
  endfunction

  owtr_pkg::phase_e         phase_q, phase_d;
  logic [COUNTER_WIDTH-1:0] tick_q, tick_d, tick_inc, len;
  logic [2:0]               bit_q, bit_d, bit_inc;
  logic [1:0]               byte_q, byte_d;
  logic [7:0]               shift_q, shift_d;
  logic [7:0]               low_q, low_d;
  logic                     rd_q, rd_d;
  logic                     fin, nodev;

  assign tick_inc = tick_q + 1'b1;
  assign bit_inc  = bit_q + 1'b1;

  always_comb begin
    case (phase_q)
      owtr_pkg::PhRstLow: len = dur(cfg_i.reset_low_us);
      owtr_pkg::PhWrLow:  len = dur(shift_q[0] ? cfg_i.short_low_us : cfg_i.slot_us);
      owtr_pkg::PhWrRel:  len = dur(shift_q[0] ? cfg_i.slot_us : cfg_i.write_tail_us);
      owtr_pkg::PhRdLow:  len = dur(cfg_i.short_low_us);
      owtr_pkg::PhRdWait: len = dur(cfg_i.sample_delay_us);
      owtr_pkg::PhRdTail: len = dur(cfg_i.read_tail_us);
      default:            len = COUNTER_WIDTH'(1);
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    low_d   = low_q;
    rd_d    = rd_q;
    fin     = 1'b0;
    nodev   = 1'b0;

    case (phase_q)
      owtr_pkg::PhIdle: begin
        if (item_i.start_convert || item_i.start_read) begin
          rd_d    = item_i.start_read;
          bit_d   = 3'd0;
          byte_d  = owtr_pkg::ByteCmd0;
          shift_d = 8'd0;
          phase_d = owtr_pkg::PhRstLow;
          tick_d  = COUNTER_WIDTH'(1);
        end
      end
      owtr_pkg::PhPresWait: begin
        if (!item_i.line_level) begin
          phase_d = owtr_pkg::PhPresEnd;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
          if (tick_inc >= dur(cfg_i.presence_wait_us)) begin
            fin   = 1'b1;
            nodev = 1'b1;
          end
        end
      end
      owtr_pkg::PhPresEnd: begin
        tick_d = tick_inc;
        if (item_i.line_level || tick_inc >= dur(cfg_i.presence_end_us)) begin
          shift_d = owtr_pkg::CmdSkipRom;
          bit_d   = 3'd0;
          byte_d  = owtr_pkg::ByteCmd0;
          phase_d = owtr_pkg::PhWrLow;
          tick_d  = COUNTER_WIDTH'(1);
        end
      end
      owtr_pkg::PhRstLow, owtr_pkg::PhWrLow, owtr_pkg::PhWrRel,
      owtr_pkg::PhRdLow, owtr_pkg::PhRdWait, owtr_pkg::PhRdTail: begin
        if (tick_q < len) begin
          tick_d = tick_inc;
        end else begin
          tick_d = COUNTER_WIDTH'(1);
          case (phase_q)
            owtr_pkg::PhRstLow: begin
              phase_d = owtr_pkg::PhPresWait;
              tick_d  = '0;
            end
            owtr_pkg::PhWrLow: phase_d = owtr_pkg::PhWrRel;
            owtr_pkg::PhWrRel: begin
              shift_d = {1'b0, shift_q[7:1]};
              bit_d   = bit_inc;
              if (bit_inc != 3'd0) begin
                phase_d = owtr_pkg::PhWrLow;
              end else if (byte_q == owtr_pkg::ByteCmd0) begin
                byte_d  = owtr_pkg::ByteCmd1;
                shift_d = rd_q ? owtr_pkg::CmdReadPad : owtr_pkg::CmdConvert;
                phase_d = owtr_pkg::PhWrLow;
              end else if (!rd_q) begin
                fin = 1'b1;
              end else begin
                byte_d  = owtr_pkg::ByteData0;
                shift_d = 8'd0;
                phase_d = owtr_pkg::PhRdLow;
              end
            end
            owtr_pkg::PhRdLow: phase_d = owtr_pkg::PhRdWait;
            owtr_pkg::PhRdWait: begin
              // sample on the first tail tick, LSB first
              shift_d = {item_i.line_level, shift_q[7:1]};
              phase_d = owtr_pkg::PhRdTail;
            end
            owtr_pkg::PhRdTail: begin
              bit_d = bit_inc;
              if (bit_inc != 3'd0) begin
                phase_d = owtr_pkg::PhRdLow;
              end else if (byte_q == owtr_pkg::ByteData0) begin
                low_d   = shift_q;
                shift_d = 8'd0;
                byte_d  = owtr_pkg::ByteData1;
                phase_d = owtr_pkg::PhRdLow;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              phase_d = owtr_pkg::PhIdle;
              tick_d  = '0;
            end
          endcase
        end
      end
      default: begin
        phase_d = owtr_pkg::PhIdle;
        tick_d  = '0;
      end
    endcase

    if (fin) begin
      phase_d = owtr_pkg::PhIdle;
      tick_d  = '0;
    end
  end

  always_comb begin
    res_o.drive_low      = (phase_d == owtr_pkg::PhRstLow) || (phase_d == owtr_pkg::PhWrLow) ||
                           (phase_d == owtr_pkg::PhRdLow);
    res_o.busy_res       = (phase_d != owtr_pkg::PhIdle);
    res_o.done_res       = fin;
    res_o.no_device      = nodev;
    res_o.is_read_result = fin && rd_q;
    res_o.temperature_raw = (fin && rd_q && !nodev) ? $signed({shift_q, low_q}) : 16'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owtr_pkg::PhIdle;
      tick_q  <= '0;
      bit_q   <= 3'd0;
      byte_q  <= owtr_pkg::ByteCmd0;
      shift_q <= 8'd0;
      low_q   <= 8'd0;
      rd_q    <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      low_q   <= low_d;
      rd_q    <= rd_d;
    end
  end

endmodule

@@ design/onewire_temperature_reader.sv @@
// ----------------------------------------------------------------------------
// One-wire temperature reader
// Single-wire bus master: reset/presence, skip-ROM, convert or read scratchpad.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is one microsecond tick carrying the sampled bus level and
//   the two start strobes. Each input beat yields exactly one output beat
//   holding drive_low (bus pull-down), busy, a done pulse, the no-device flag,
//   the read flag and the signed raw temperature in 1/16 degree units.
//   A beat is taken when valid is high and stall is low on that channel.
//   An accepted beat waits in the input register until the result register can
//   take it; the sequencer then steps and its result is loaded there.
//   It takes one beat per cycle unless the receiver stalls; one step per beat.
//   When the receiver stalls, the result register holds, the input register
//   fills and then in_stall_o rises; no beat is lost or repeated.
//   The user must write timing registers (cfg_we_i/cfg_idx_i/cfg_wdata_i) only
//   while idle, not enforced by the block; they take effect on the next tick.
//   Reset returns the sequencer to idle, empties both registers and loads the
//   default timings. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "onewire_temperature_reader_macros.svh"

module onewire_temperature_reader #(
  parameter int unsigned COUNTER_WIDTH = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  owtr_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output owtr_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [owtr_pkg::RegWidth-1:0] cfg_wdata_i
);

  owtr_pkg::cfg_t cfg;
  owtr_pkg::in_t  s1_data_q;
  owtr_pkg::out_t out_data_q, res;
  logic           s1_valid_q, s1_valid_d;
  logic           out_valid_q, out_valid_d;
  logic           out_ready, s1_ready, step;

  owtr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  owtr_seq #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (s1_data_q),
    .res_o  (res)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_ready;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;

  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = out_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `OWTR_ASSERT_IMP(a_done_ends_busy, clk_i, rst_ni, out_valid_q && out_data_q.done_res, !out_data_q.busy_res)
  `OWTR_ASSERT_IMP(a_nodev_with_done, clk_i, rst_ni, out_valid_q && out_data_q.no_device, out_data_q.done_res && (out_data_q.temperature_raw == 16'sd0))
  `OWTR_ASSERT_IMP(a_temp_only_on_read, clk_i, rst_ni, out_valid_q && (out_data_q.temperature_raw != 16'sd0), out_data_q.done_res && out_data_q.is_read_result)
  `OWTR_ASSERT_IMP(a_drive_while_busy, clk_i, rst_ni, out_valid_q && out_data_q.drive_low, out_data_q.busy_res)
  `OWTR_ASSERT_NXT(a_s1_held_on_block, clk_i, rst_ni, s1_valid_q && !out_ready, s1_valid_q && $stable(s1_data_q))

endmodule
